[rtl/core/kfsi_pkg.sv]
// Shared types, widths and constants for the keyframe size interpolator.
// No dependencies; compile first.
package kfsi_pkg;

   // Field widths
   localparam int AGE_W      = 24;
   localparam int LIFE_W     = 25;
   localparam int TIME_W     = 16;
   localparam int SIZE_W     = 16;

   // Keys: storage always holds KEY_COUNT, NUM_KEYS of them take part (2..4)
   localparam int KEY_COUNT  = 4;
   localparam int NUM_KEYS   = 4;
   localparam int KEY_IDX_W  = $clog2(KEY_COUNT);

   // Divider: one quotient bit per stage
   localparam int DIV_STEPS  = 16;
   localparam int QUOT_W     = DIV_STEPS;
   localparam int DIV_W      = 25;

   // Interpolation products
   localparam int PROD_W     = SIZE_W + TIME_W;
   localparam int NUM_W      = PROD_W + 1;

   // Register port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_TIME_A = 4'd0,
      REG_KEY_TIME_B = 4'd1,
      REG_KEY_TIME_C = 4'd2,
      REG_KEY_TIME_D = 4'd3,
      REG_KEY_SIZE_A = 4'd4,
      REG_KEY_SIZE_B = 4'd5,
      REG_KEY_SIZE_C = 4'd6,
      REG_KEY_SIZE_D = 4'd7
   } kfsi_reg_type;

   localparam logic [KEY_COUNT-1:0][TIME_W-1:0] KEY_TIME_RESET =
      {16'd32768, 16'd21845, 16'd10923, 16'd0};
   localparam logic [KEY_COUNT-1:0][SIZE_W-1:0] KEY_SIZE_RESET =
      {16'd256, 16'd256, 16'd256, 16'd256};

   typedef struct packed {
      logic [KEY_COUNT-1:0][TIME_W-1:0] key_time;
      logic [KEY_COUNT-1:0][SIZE_W-1:0] key_size;
   } kfsi_keys_type;

   // Sideband that rides along with each item through the dividers
   typedef struct packed {
      logic              overrun;
      logic              size_valid;
      logic              bypass_en;
      logic [QUOT_W-1:0] bypass_val;
   } kfsi_tag_type;

endpackage

[rtl/core/kfsi_if.sv]
// Valid/ready channel interfaces for the keyframe size interpolator.
// Depends on kfsi_pkg.
interface kfsi_req_if;
   logic                               valid;
   logic                               ready;
   logic        [kfsi_pkg::AGE_W-1:0]  current_age;
   logic signed [kfsi_pkg::LIFE_W-1:0] total_lifetime;

   modport source (output valid, current_age, total_lifetime, input ready);
   modport sink   (input valid, current_age, total_lifetime, output ready);
endinterface

interface kfsi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kfsi_pkg::SIZE_W-1:0]   size_value;
   logic                          size_valid;
   logic                          age_overrun;

   modport source (output valid, size_value, size_valid, age_overrun, input ready);
   modport sink   (input valid, size_value, size_valid, age_overrun, output ready);
endinterface

interface kfsi_csr_if;
   logic                              valid;
   logic                              ready;
   logic [kfsi_pkg::CSR_IDX_W-1:0]    index;
   logic [kfsi_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/kfsi_csr.sv]
// Key time and key size registers, written through the register channel.
// Depends on kfsi_pkg and kfsi_if.
module kfsi_csr (
   input  logic                    clock,
   input  logic                    reset,
   kfsi_csr_if.sink                csr_bus,
   output kfsi_pkg::kfsi_keys_type keys
);
   import kfsi_pkg::*;

   logic [KEY_COUNT-1:0][TIME_W-1:0] key_time_ff;
   logic [KEY_COUNT-1:0][SIZE_W-1:0] key_size_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_time_ff <= KEY_TIME_RESET;
         key_size_ff <= KEY_SIZE_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index) inside
            REG_KEY_TIME_A, REG_KEY_TIME_B, REG_KEY_TIME_C, REG_KEY_TIME_D: begin
               key_time_ff[csr_bus.index[KEY_IDX_W-1:0]] <= csr_bus.data;
            end
            REG_KEY_SIZE_A, REG_KEY_SIZE_B, REG_KEY_SIZE_C, REG_KEY_SIZE_D: begin
               key_size_ff[csr_bus.index[KEY_IDX_W-1:0]] <= csr_bus.data;
            end
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   assign keys.key_time = key_time_ff;
   assign keys.key_size = key_size_ff;

endmodule

[rtl/core/kfsi_prep.sv]
// Input stage: lifetime clamp, overrun and saturation detect, divider setup.
// Depends on kfsi_pkg.
module kfsi_prep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic        [kfsi_pkg::AGE_W-1:0]  current_age,
   input  logic signed [kfsi_pkg::LIFE_W-1:0] total_lifetime,
   output logic                              out_valid,
   output logic        [kfsi_pkg::DIV_W-1:0]  out_rem,
   output logic        [kfsi_pkg::QUOT_W-1:0] out_low,
   output logic        [kfsi_pkg::DIV_W-1:0]  out_divisor,
   output kfsi_pkg::kfsi_tag_type             out_tag
);
   import kfsi_pkg::*;

   logic [AGE_W-1:0] life_in;
   logic             overrun_in;
   logic             sat_in;

   logic             vld_ff;
   logic [AGE_W-1:0] age_ff;
   logic [AGE_W-1:0] life_ff;
   logic             overrun_ff;
   logic             sat_ff;

   always_comb begin
      // negative or zero lifetime counts as 1 ms
      if (total_lifetime[LIFE_W-1] || (total_lifetime == '0)) begin
         life_in = AGE_W'(1);
      end else begin
         life_in = total_lifetime[AGE_W-1:0];
      end
      overrun_in = current_age > life_in;
      // quotient would need more than QUOT_W bits once age >= 2 * life
      sat_in     = {1'b0, current_age} >= {life_in, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         age_ff     <= current_age;
         life_ff    <= life_in;
         overrun_ff <= overrun_in;
         sat_ff     <= sat_in;
      end
   end

   // dividend is age << 15; top part below the divisor seeds the remainder
   assign out_valid   = vld_ff;
   assign out_rem     = DIV_W'(age_ff[AGE_W-1:1]);
   assign out_low     = {age_ff[0], {(QUOT_W-1){1'b0}}};
   assign out_divisor = DIV_W'(life_ff);

   always_comb begin
      out_tag            = '0;
      out_tag.overrun    = overrun_ff;
      out_tag.bypass_en  = sat_ff;
      out_tag.bypass_val = '1;
   end

endmodule

[rtl/core/kfsi_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on kfsi_pkg.
module kfsi_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [kfsi_pkg::DIV_W-1:0]   in_rem,
   input  logic [kfsi_pkg::QUOT_W-1:0]  in_low,
   input  logic [kfsi_pkg::DIV_W-1:0]   in_divisor,
   input  kfsi_pkg::kfsi_tag_type       in_tag,
   output logic                         out_valid,
   output logic [kfsi_pkg::QUOT_W-1:0]  out_quot,
   output kfsi_pkg::kfsi_tag_type       out_tag
);
   import kfsi_pkg::*;

   logic [DIV_STEPS-1:0] vld_ff;
   logic [DIV_W-1:0]     rem_ff     [DIV_STEPS];
   logic [DIV_W-1:0]     divisor_ff [DIV_STEPS];
   logic [QUOT_W-1:0]    low_ff     [DIV_STEPS];
   logic [QUOT_W-1:0]    quot_ff    [DIV_STEPS];
   kfsi_tag_type         tag_ff     [DIV_STEPS];

   // stage view: index 0 is the input, index k+1 the registers of step k
   logic [DIV_STEPS:0]   stage_vld;
   logic [DIV_W-1:0]     stage_rem  [DIV_STEPS+1];
   logic [DIV_W-1:0]     stage_div  [DIV_STEPS+1];
   logic [QUOT_W-1:0]    stage_low  [DIV_STEPS+1];
   logic [QUOT_W-1:0]    stage_quot [DIV_STEPS+1];
   kfsi_tag_type         stage_tag  [DIV_STEPS+1];

   assign stage_vld[0]  = in_valid;
   assign stage_rem[0]  = in_rem;
   assign stage_div[0]  = in_divisor;
   assign stage_low[0]  = in_low;
   assign stage_quot[0] = '0;
   assign stage_tag[0]  = in_tag;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DIV_W-1:0]  shifted;
      logic              ge;
      logic [DIV_W-1:0]  rem_in;
      logic [QUOT_W-1:0] quot_in;
      logic [QUOT_W-1:0] low_in;

      always_comb begin
         shifted = {stage_rem[k][DIV_W-2:0], stage_low[k][QUOT_W-1]};
         ge      = shifted >= stage_div[k];
         rem_in  = ge ? (shifted - stage_div[k]) : shifted;
         quot_in = {stage_quot[k][QUOT_W-2:0], ge};
         low_in  = {stage_low[k][QUOT_W-2:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= stage_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]     <= rem_in;
            divisor_ff[k] <= stage_div[k];
            low_ff[k]     <= low_in;
            quot_ff[k]    <= quot_in;
            tag_ff[k]     <= stage_tag[k];
         end
      end

      assign stage_vld[k+1]  = vld_ff[k];
      assign stage_rem[k+1]  = rem_ff[k];
      assign stage_div[k+1]  = divisor_ff[k];
      assign stage_low[k+1]  = low_ff[k];
      assign stage_quot[k+1] = quot_ff[k];
      assign stage_tag[k+1]  = tag_ff[k];
   end

   assign out_valid = stage_vld[DIV_STEPS];
   assign out_tag   = stage_tag[DIV_STEPS];
   assign out_quot  = stage_tag[DIV_STEPS].bypass_en ? stage_tag[DIV_STEPS].bypass_val
                                                     : stage_quot[DIV_STEPS];

endmodule

[rtl/core/kfsi_lerp.sv]
// Key search and weighted sum: bracket/select, multiply, add, then divider setup.
// Depends on kfsi_pkg.
module kfsi_lerp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [kfsi_pkg::QUOT_W-1:0]  in_t,
   input  kfsi_pkg::kfsi_tag_type       in_tag,
   input  kfsi_pkg::kfsi_keys_type      keys,
   output logic                         out_valid,
   output logic [kfsi_pkg::DIV_W-1:0]   out_rem,
   output logic [kfsi_pkg::QUOT_W-1:0]  out_low,
   output logic [kfsi_pkg::DIV_W-1:0]   out_divisor,
   output kfsi_pkg::kfsi_tag_type       out_tag
);
   import kfsi_pkg::*;

   // stage A: bracket and operand select
   logic                 found;
   logic [KEY_IDX_W-1:0] sel;
   logic [KEY_IDX_W-1:0] sel_prev;
   logic [TIME_W-1:0]    ta;
   logic [TIME_W-1:0]    tb;
   logic [SIZE_W-1:0]    sa;
   logic [SIZE_W-1:0]    sb;
   logic [TIME_W-1:0]    span_in;
   logic [TIME_W-1:0]    d_in;
   kfsi_tag_type         tag_a_in;

   logic                 vld_a_ff;
   kfsi_tag_type         tag_a_ff;
   logic [SIZE_W-1:0]    sa_ff;
   logic [SIZE_W-1:0]    sb_ff;
   logic [TIME_W-1:0]    span_a_ff;
   logic [TIME_W-1:0]    wa_ff;
   logic [TIME_W-1:0]    wb_ff;

   // stage B: products
   logic                 vld_b_ff;
   kfsi_tag_type         tag_b_ff;
   logic [TIME_W-1:0]    span_b_ff;
   logic [PROD_W-1:0]    prod_a_ff;
   logic [PROD_W-1:0]    prod_b_ff;

   // stage C: sum
   logic                 vld_c_ff;
   kfsi_tag_type         tag_c_ff;
   logic [TIME_W-1:0]    span_c_ff;
   logic [NUM_W-1:0]     num_ff;

   always_comb begin
      found = 1'b0;
      sel   = KEY_IDX_W'(1);
      for (int i = 1; i < NUM_KEYS; i++) begin
         if (!found && (keys.key_time[i] >= in_t)) begin
            found = 1'b1;
            sel   = KEY_IDX_W'(i);
         end
      end
      sel_prev = sel - 1'b1;
      ta       = keys.key_time[sel_prev];
      tb       = keys.key_time[sel];
      sa       = keys.key_size[sel_prev];
      sb       = keys.key_size[sel];
      span_in  = tb - ta;
      d_in     = in_t - ta;

      tag_a_in            = in_tag;
      tag_a_in.size_valid = found;
      tag_a_in.bypass_en  = 1'b1;
      tag_a_in.bypass_val = '0;
      if (!found) begin
         tag_a_in.bypass_val = '0;
      end else if (tb <= ta) begin
         tag_a_in.bypass_val = sb;      // flat or descending segment
      end else if (in_t <= ta) begin
         tag_a_in.bypass_val = sa;      // before the segment, no extrapolation
      end else begin
         tag_a_in.bypass_en  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_a_ff  <= tag_a_in;
         sa_ff     <= sa;
         sb_ff     <= sb;
         span_a_ff <= span_in;
         wa_ff     <= span_in - d_in;
         wb_ff     <= d_in;

         tag_b_ff  <= tag_a_ff;
         span_b_ff <= span_a_ff;
         prod_a_ff <= PROD_W'(sa_ff) * PROD_W'(wa_ff);
         prod_b_ff <= PROD_W'(sb_ff) * PROD_W'(wb_ff);

         tag_c_ff  <= tag_b_ff;
         span_c_ff <= span_b_ff;
         num_ff    <= NUM_W'(prod_a_ff) + NUM_W'(prod_b_ff);
      end
   end

   // quotient fits QUOT_W bits, so the top part of num is below span
   assign out_valid   = vld_c_ff;
   assign out_rem     = DIV_W'(num_ff[NUM_W-1:QUOT_W]);
   assign out_low     = num_ff[QUOT_W-1:0];
   assign out_divisor = DIV_W'(span_c_ff);
   assign out_tag     = tag_c_ff;

endmodule

[rtl/core/keyframe_size_interpolator.sv]
// Top level of the keyframe size interpolator.
// Depends on kfsi_pkg, kfsi_if, kfsi_csr, kfsi_prep, kfsi_div and kfsi_lerp.

// Maps a particle's age and lifetime to a Q8.8 size by piecewise-linear
// interpolation over four programmable keys. The lifetime is clamped to at
// least 1 ms, t = age * 32768 / lifetime is formed in Q1.15 (saturating at
// 0xFFFF), the first key from 1 up whose time is >= t picks the segment, and
// the size is the truncated weighted average of that segment's two sizes.
// No bracketing key gives size_valid = 0 with size_value = 0; age beyond
// lifetime sets age_overrun. The datapath is a fixed 36-stage pipeline:
// 1 input stage, 16 stages of the t divider (one quotient bit each), 3 stages
// of key select / multiply / add, and 16 stages of the size divider. One
// transfer in per clock and one out per clock while rsp is not stalled. The
// first stage loads on the req transfer edge; the item then passes through
// the t divider, the key select / multiply / add stages and the size
// divider before rsp valid rises. A stall on rsp holds the whole pipe:
// req_bus.ready drops in the same cycle rsp is valid and not taken.
// Key registers are written through csr_bus (always ready) and should only
// change while no item is in flight.
module keyframe_size_interpolator (
   input  logic      clock,
   input  logic      reset,
   kfsi_req_if.sink  req_bus,
   kfsi_rsp_if.source rsp_bus,
   kfsi_csr_if.sink  csr_bus
);
   import kfsi_pkg::*;

   // pipeline-wide advance: last stage empty or being taken
   logic adv;

   kfsi_keys_type keys;

   // prep -> t divider
   logic              prep_valid;
   logic [DIV_W-1:0]  prep_rem;
   logic [QUOT_W-1:0] prep_low;
   logic [DIV_W-1:0]  prep_divisor;
   kfsi_tag_type      prep_tag;

   // t divider -> lerp
   logic              t_valid;
   logic [QUOT_W-1:0] t_value;
   kfsi_tag_type      t_tag;

   // lerp -> size divider
   logic              lerp_valid;
   logic [DIV_W-1:0]  lerp_rem;
   logic [QUOT_W-1:0] lerp_low;
   logic [DIV_W-1:0]  lerp_divisor;
   kfsi_tag_type      lerp_tag;

   // size divider -> rsp
   logic              size_valid_q;
   logic [QUOT_W-1:0] size_quot;
   kfsi_tag_type      size_tag;

   assign adv           = !size_valid_q || rsp_bus.ready;
   assign req_bus.ready = adv;

   kfsi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .keys    (keys)
   );

   kfsi_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (req_bus.valid),
      .current_age    (req_bus.current_age),
      .total_lifetime (req_bus.total_lifetime),
      .out_valid      (prep_valid),
      .out_rem        (prep_rem),
      .out_low        (prep_low),
      .out_divisor    (prep_divisor),
      .out_tag        (prep_tag)
   );

   // t = (age << 15) / life
   kfsi_div u_t_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (prep_valid),
      .in_rem     (prep_rem),
      .in_low     (prep_low),
      .in_divisor (prep_divisor),
      .in_tag     (prep_tag),
      .out_valid  (t_valid),
      .out_quot   (t_value),
      .out_tag    (t_tag)
   );

   kfsi_lerp u_lerp (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (t_valid),
      .in_t        (t_value),
      .in_tag      (t_tag),
      .keys        (keys),
      .out_valid   (lerp_valid),
      .out_rem     (lerp_rem),
      .out_low     (lerp_low),
      .out_divisor (lerp_divisor),
      .out_tag     (lerp_tag)
   );

   // size = (sa * (span - d) + sb * d) / span, or the bypass value
   kfsi_div u_size_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (lerp_valid),
      .in_rem     (lerp_rem),
      .in_low     (lerp_low),
      .in_divisor (lerp_divisor),
      .in_tag     (lerp_tag),
      .out_valid  (size_valid_q),
      .out_quot   (size_quot),
      .out_tag    (size_tag)
   );

   assign rsp_bus.valid       = size_valid_q;
   assign rsp_bus.size_value  = SIZE_W'(size_quot);
   assign rsp_bus.size_valid  = size_tag.size_valid;
   assign rsp_bus.age_overrun = size_tag.overrun;

endmodule

[rtl/core/kfsi_checker.sv]
// Port-level assertions for keyframe_size_interpolator, bound to the top level.
// Depends on kfsi_pkg and keyframe_size_interpolator.
module kfsi_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [kfsi_pkg::SIZE_W-1:0] rsp_size_value,
   input logic                        rsp_size_valid,
   input logic                        rsp_age_overrun
);
   import kfsi_pkg::*;

   // stalled result holds until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_size_value)
         && $stable(rsp_size_valid) && $stable(rsp_age_overrun))
      else $error("rsp payload changed while stalled");

   // input side stalls exactly when the output is blocked
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (req_ready == (!rsp_valid || rsp_ready)))
      else $error("req ready does not follow rsp backpressure");

   // unbracketed result carries a zero size
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_size_valid |-> (rsp_size_value == '0))
      else $error("size_value nonzero with size_valid low");

   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind keyframe_size_interpolator kfsi_checker u_kfsi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_size_value  (rsp_bus.size_value),
   .rsp_size_valid  (rsp_bus.size_valid),
   .rsp_age_overrun (rsp_bus.age_overrun)
);
